// File: hdl/mtf_pkg.sv
// shared types and constants for the move-to-front recent list
package mtf_pkg;

    localparam int LIST_DEPTH = 128;
    localparam int KEY_WIDTH  = 32;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int MAX_W      = 8;
    localparam logic [MAX_W-1:0] MAX_RESET = 8'd100;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_READ   = 2'd1,
        OP_APPEND = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_SCAN,
        S_TAIL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_count;
        logic append_write;
        logic rd_index;
        logic scan_start;
        logic scan_step;
        logic tail_write;
        logic res_hit;
        logic res_evict_key;
        logic res_evict_tail;
        logic res_read;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hit_now;
        logic last;
        logic room;
        logic lim_zero;
        logic count_zero;
        logic idx_ok;
        logic out_free;
    } t_status;

endpackage

// File: hdl/mtf_ctrl.sv
// sequencer for add, read, append and clear over the key memory
module mtf_ctrl
    import mtf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                unique case (i_status.op)
                    OP_CLEAR: begin
                        o_cmd.clear_count = 1'b1;
                    end
                    OP_APPEND: begin
                        if (i_status.room) begin
                            o_cmd.append_write = 1'b1;
                        end else begin
                            o_cmd.res_evict_key = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (i_status.idx_ok) begin
                            o_cmd.rd_index = 1'b1;
                            n_state        = S_RDWAIT;
                        end
                    end
                    OP_ADD: begin
                        priority if (i_status.lim_zero) begin
                            o_cmd.res_evict_key = 1'b1;
                        end else if (i_status.count_zero) begin
                            // empty list: the key simply lands at the front
                            o_cmd.append_write = 1'b1;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_RDWAIT: begin
                o_cmd.res_read = 1'b1;
                n_state        = S_EMIT;
            end
            S_SCAN: begin
                // each cycle writes the carried word down one slot
                o_cmd.scan_step = 1'b1;
                priority if (i_status.hit_now) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_status.last) begin
                    if (i_status.room) begin
                        n_state = S_TAIL;
                    end else begin
                        o_cmd.res_evict_tail = 1'b1;
                        n_state              = S_EMIT;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_TAIL: begin
                o_cmd.tail_write = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/mtf_dpath.sv
// key memory, count, limit register, scan registers and output word
module mtf_dpath
    import mtf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [1:0]           i_op,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [ADDR_W-1:0]    i_index,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [ADDR_W-1:0]    o_hit_position,
    output logic                 o_evicted_valid,
    output logic [KEY_WIDTH-1:0] o_evicted_key,
    output logic                 o_read_valid,
    output logic [KEY_WIDTH-1:0] o_read_key,
    output logic [CNT_W-1:0]     o_list_count,
    input  logic                 i_cfg_wr,
    input  logic [MAX_W-1:0]     i_cfg_data,
    output logic [MAX_W-1:0]     o_max_entries
);

    logic [KEY_WIDTH-1:0] r_mem [LIST_DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    t_op                  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [ADDR_W-1:0]    r_index;
    logic [ADDR_W-1:0]    r_addr;
    logic [KEY_WIDTH-1:0] r_carry;
    logic [CNT_W-1:0]     r_count;
    logic [MAX_W-1:0]     r_max;

    logic                 r_res_hit;
    logic [ADDR_W-1:0]    r_res_pos;
    logic                 r_res_ev;
    logic [KEY_WIDTH-1:0] r_res_ev_key;
    logic                 r_res_rd;
    logic [KEY_WIDTH-1:0] r_res_rd_key;

    logic                 r_o_valid;

    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     cfg_lim;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [KEY_WIDTH-1:0] mem_wd;
    logic [ADDR_W-1:0]    mem_ra;

    assign lim     = (r_max > MAX_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH) : CNT_W'(r_max);
    assign cfg_lim = (i_cfg_data > MAX_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH)
                                                       : CNT_W'(i_cfg_data);

    // write port: append and tail go at the count, scan steps at the scan address
    always_comb begin
        mem_we = i_cmd.append_write | i_cmd.scan_step | i_cmd.tail_write;
        mem_wa = i_cmd.scan_step ? r_addr : r_count[ADDR_W-1:0];
        mem_wd = i_cmd.append_write ? r_key : r_carry;
    end

    always_comb begin
        priority if (i_cmd.rd_index) begin
            mem_ra = r_index;
        end else if (i_cmd.scan_start) begin
            mem_ra = '0;
        end else begin
            mem_ra = r_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_op);
            r_key   <= i_key;
            r_index <= i_index;
        end
        if (i_cmd.scan_start) begin
            r_addr  <= '0;
            r_carry <= r_key;
        end else if (i_cmd.scan_step) begin
            r_addr  <= r_addr + ADDR_W'(1);
            r_carry <= r_rdata;
        end
    end

    // pending result word, built up while the item is worked on
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_hit    <= 1'b0;
            r_res_pos    <= '0;
            r_res_ev     <= 1'b0;
            r_res_ev_key <= '0;
            r_res_rd     <= 1'b0;
            r_res_rd_key <= '0;
        end else begin
            if (i_cmd.res_hit) begin
                r_res_hit <= 1'b1;
                r_res_pos <= r_addr;
            end
            if (i_cmd.res_evict_key) begin
                r_res_ev     <= 1'b1;
                r_res_ev_key <= r_key;
            end
            if (i_cmd.res_evict_tail) begin
                r_res_ev     <= 1'b1;
                r_res_ev_key <= r_rdata;
            end
            if (i_cmd.res_read) begin
                r_res_rd     <= 1'b1;
                r_res_rd_key <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= MAX_RESET;
        end else begin
            if (i_cfg_wr) begin
                r_max <= i_cfg_data;
                if (r_count > cfg_lim) begin
                    r_count <= cfg_lim;
                end
            end else if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.append_write || i_cmd.tail_write) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit           <= r_res_hit;
            o_hit_position  <= r_res_pos;
            o_evicted_valid <= r_res_ev;
            o_evicted_key   <= r_res_ev_key;
            o_read_valid    <= r_res_rd;
            o_read_key      <= r_res_rd_key;
            o_list_count    <= r_count;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_max_entries = r_max;

    always_comb begin
        o_status.op         = r_op;
        o_status.hit_now    = (r_rdata == r_key);
        o_status.last       = ({1'b0, r_addr} == (r_count - CNT_W'(1)));
        o_status.room       = (r_count < lim);
        o_status.lim_zero   = (lim == '0);
        o_status.count_zero = (r_count == '0);
        o_status.idx_ok     = ({1'b0, r_index} < r_count);
        o_status.out_free   = !r_o_valid || i_ready;
    end

`ifndef SYNTHESIS
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lim)
        else $error("list count above limit");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> ({1'b0, r_addr} < r_count))
        else $error("scan past the end of the list");

    a_tail_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tail_write |-> (r_count < lim))
        else $error("tail write with full list");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || i_ready))
        else $error("output word overwritten before it was taken");

    a_count_holds_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_hit && !i_cfg_wr) |=> $stable(r_count))
        else $error("count changed on an add hit");
`endif

endmodule

// File: hdl/move_to_front_recent_list.sv
// top level: most-recently-used key list with a length limit
// from input accept to output valid: clear, append, a read out of range and an add to an
//   empty list or at limit zero pass decode and emit; a read passes decode, a read wait
//   and emit; an add scans to a hit or the last key, then writes the tail if it grows
// the add time comes from one pass over the key memory, one entry per cycle
// one word at a time: the next word is taken only after the result is registered
// synchronous active-low reset empties the list and sets the limit to 100; key memory is not cleared
module move_to_front_recent_list
    import mtf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [ADDR_W-1:0]    i_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [ADDR_W-1:0]    o_hit_position,
    output logic                 o_evicted_valid,
    output logic [KEY_WIDTH-1:0] o_evicted_key,
    output logic                 o_read_valid,
    output logic [KEY_WIDTH-1:0] o_read_key,
    output logic [CNT_W-1:0]     o_list_count,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_cmd             cmd;
    t_status          status;
    logic             cfg_wr;
    logic [MAX_W-1:0] max_entries;

    assign pready = 1'b1;
    // one register, seen at addresses 0 to 3; writes with paddr[2] set are dropped
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(max_entries) : 32'd0;

    mtf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mtf_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_op            (i_op),
        .i_key           (i_key),
        .i_index         (i_index),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_hit_position  (o_hit_position),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_read_valid    (o_read_valid),
        .o_read_key      (o_read_key),
        .o_list_count    (o_list_count),
        .i_cfg_wr        (cfg_wr),
        .i_cfg_data      (pwdata[MAX_W-1:0]),
        .o_max_entries   (max_entries)
    );

endmodule

// File: verif/testbench.sv
// testbench for the move-to-front recent list: directed table, then random phases per limit
module testbench;
    import mtf_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = 3'd0;    // max_entries register
    localparam logic [2:0] SPARE_ADDR = 3'd4;    // no register here, writes are ignored
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int N_PHASES = 14;
    localparam int N_ROWS = 29;

    typedef struct packed {
        logic                 hit;
        logic [ADDR_W-1:0]    hit_pos;
        logic                 ev_valid;
        logic [KEY_WIDTH-1:0] ev_key;
        logic                 rd_valid;
        logic [KEY_WIDTH-1:0] rd_key;
        logic [CNT_W-1:0]     count;
    } list_result_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [2:0]           addr;
        logic [31:0]          wdata;
        t_op                  op;
        logic [KEY_WIDTH-1:0] key;
        logic [ADDR_W-1:0]    idx;
        logic                 typed;
        list_result_t         want;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_op;
    logic [KEY_WIDTH-1:0] i_key;
    logic [ADDR_W-1:0]    i_index;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_hit;
    logic [ADDR_W-1:0]    o_hit_position;
    logic                 o_evicted_valid;
    logic [KEY_WIDTH-1:0] o_evicted_key;
    logic                 o_read_valid;
    logic [KEY_WIDTH-1:0] o_read_key;
    logic [CNT_W-1:0]     o_list_count;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // mirror of the list
    logic [KEY_WIDTH-1:0] held_keys [LIST_DEPTH];
    int                   held_count;
    logic [MAX_W-1:0]     limit_reg;
    int                   limit_eff;

    list_result_t awaited_results [$];
    logic [KEY_WIDTH-1:0] key_pool [LIST_DEPTH + 4];
    int pool_n;
    int steady_left;
    int errors;
    int cycle_count;
    list_result_t mon_want;
    list_result_t mon_got;
    stim_row_t dir_rows [N_ROWS];

    move_to_front_recent_list DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_key(i_key), .i_index(i_index),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_hit(o_hit), .o_hit_position(o_hit_position),
        .o_evicted_valid(o_evicted_valid), .o_evicted_key(o_evicted_key),
        .o_read_valid(o_read_valid), .o_read_key(o_read_key),
        .o_list_count(o_list_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic list_result_t apply_mru_op(t_op op, logic [KEY_WIDTH-1:0] key,
                                                  logic [ADDR_W-1:0] idx);
        list_result_t r;
        int found;
        int top;
        r = '0;
        case (op)
            OP_ADD: begin
                found = held_count;
                // walk down so the most recent match wins
                for (int i = held_count - 1; i >= 0; i--)
                    if (held_keys[i] == key) found = i;
                if (found < held_count) begin
                    r.hit = 1'b1;
                    r.hit_pos = ADDR_W'(found);
                    top = found;
                end else begin
                    top = held_count;
                    if (held_count + 1 > limit_eff) begin
                        r.ev_valid = 1'b1;
                        if (held_count == 0) begin
                            r.ev_key = key;
                        end else begin
                            r.ev_key = held_keys[held_count - 1];
                            held_count--;
                            top = held_count;
                        end
                    end
                end
                // limit zero drops the new key right away
                if (limit_eff != 0) begin
                    for (int i = top; i > 0; i--)
                        held_keys[i] = held_keys[i - 1];
                    held_keys[0] = key;
                    if (!r.hit) held_count++;
                end
            end
            OP_READ: begin
                if (idx < held_count) begin
                    r.rd_valid = 1'b1;
                    r.rd_key = held_keys[idx];
                end
            end
            OP_APPEND: begin
                if (held_count < limit_eff) begin
                    held_keys[held_count] = key;
                    held_count++;
                end else begin
                    r.ev_valid = 1'b1;
                    r.ev_key = key;
                end
            end
            default: held_count = 0;
        endcase
        r.count = CNT_W'(held_count);
        return r;
    endfunction

    function automatic list_result_t res(int hit, int pos, int evv, logic [31:0] evk,
                                         int rdv, logic [31:0] rdk, int cnt);
        list_result_t r;
        r.hit = 1'(hit);
        r.hit_pos = ADDR_W'(pos);
        r.ev_valid = 1'(evv);
        r.ev_key = evk;
        r.rd_valid = 1'(rdv);
        r.rd_key = rdk;
        r.count = CNT_W'(cnt);
        return r;
    endfunction

    function automatic stim_row_t op_row(t_op op, logic [31:0] key, int idx);
        stim_row_t s;
        s = '0;
        s.op = op;
        s.key = key;
        s.idx = ADDR_W'(idx);
        return s;
    endfunction

    function automatic stim_row_t chk_row(t_op op, logic [31:0] key, int idx,
                                          list_result_t want);
        stim_row_t s;
        s = op_row(op, key, idx);
        s.typed = 1'b1;
        s.want = want;
        return s;
    endfunction

    function automatic stim_row_t cfg_row(logic [2:0] addr, logic [31:0] data);
        stim_row_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.addr = addr;
        s.wdata = data;
        return s;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(t_op op, logic [KEY_WIDTH-1:0] key, logic [ADDR_W-1:0] idx,
                             logic typed, list_result_t want);
        int gap;
        int r;
        list_result_t pred;
        gap = 0;
        if (steady_left > 0) begin
            steady_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) steady_left = $urandom_range(20, 60);
            else if (r < 55) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else gap = $urandom_range(6, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_key <= key;
        i_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        pred = apply_mru_op(op, key, idx);
        awaited_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // waits for the list to go quiet, then writes one register; a limit write is read back
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        if (addr == LIMIT_ADDR) begin
            limit_reg = data[MAX_W-1:0];
            limit_eff = (limit_reg > LIST_DEPTH) ? LIST_DEPTH : limit_reg;
            if (held_count > limit_eff) held_count = limit_eff;
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== {24'b0, limit_reg}) begin
                $display("%0t: limit readback expected %h actual %h",
                         $realtime, {24'b0, limit_reg}, prdata);
                errors++;
            end
            @(negedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        // fresh keys sized to the limit so adds hit often
        pool_n = limit_eff + 3;
        for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
    endtask

    task automatic report(string name, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
        errors++;
    endtask

    // receiver: long ready stretches, short and long stalls
    initial begin
        int mode;
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(30, 200)) @(negedge i_clk);
            end else if (mode < 9) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            mon_got = res(int'(o_hit), int'(o_hit_position), int'(o_evicted_valid),
                          o_evicted_key, int'(o_read_valid), o_read_key,
                          int'(o_list_count));
            if (awaited_results.size() == 0) begin
                $display("%0t: word with nothing expected, count %h", $realtime, o_list_count);
                errors++;
            end else begin
                mon_want = awaited_results.pop_front();
                if (mon_got.hit !== mon_want.hit)
                    report("hit", 32'(mon_want.hit), 32'(mon_got.hit));
                if (mon_got.hit_pos !== mon_want.hit_pos)
                    report("hit_position", 32'(mon_want.hit_pos), 32'(mon_got.hit_pos));
                if (mon_got.ev_valid !== mon_want.ev_valid)
                    report("evicted_valid", 32'(mon_want.ev_valid), 32'(mon_got.ev_valid));
                if (mon_got.ev_key !== mon_want.ev_key)
                    report("evicted_key", mon_want.ev_key, mon_got.ev_key);
                if (mon_got.rd_valid !== mon_want.rd_valid)
                    report("read_valid", 32'(mon_want.rd_valid), 32'(mon_got.rd_valid));
                if (mon_got.rd_key !== mon_want.rd_key)
                    report("read_key", mon_want.rd_key, mon_got.rd_key);
                if (mon_got.count !== mon_want.count)
                    report("list_count", 32'(mon_want.count), 32'(mon_got.count));
            end
        end
    end

    initial begin
        int phase_limit [N_PHASES];
        int phase_items [N_PHASES];
        int r;
        int clear_at;
        t_op op;
        logic [KEY_WIDTH-1:0] key;
        logic [ADDR_W-1:0] idx;

        phase_limit = '{3, 1, 0, 8, 2, 16, 128, 255, 5, 4, 200, 32, 100, 6};
        phase_items = '{100, 60, 50, 100, 80, 100, 80, 60, 100, 100, 50, 120, 80, 120};
        dir_rows = '{
            chk_row(OP_READ,   32'h0000_0000,   0, res(0, 0, 0, 0, 0, 0, 0)),
            chk_row(OP_READ,   32'hFFFF_FFFF, 127, res(0, 0, 0, 0, 0, 0, 0)),
            chk_row(OP_CLEAR,  32'h0000_0000,   0, res(0, 0, 0, 0, 0, 0, 0)),
            chk_row(OP_ADD,    32'h0000_0000,   0, res(0, 0, 0, 0, 0, 0, 1)),
            chk_row(OP_ADD,    32'hFFFF_FFFF,   0, res(0, 0, 0, 0, 0, 0, 2)),
            chk_row(OP_ADD,    32'h0000_0000,   0, res(1, 1, 0, 0, 0, 0, 2)),
            chk_row(OP_READ,   32'h0000_0000,   0, res(0, 0, 0, 0, 1, 32'h0, 2)),
            chk_row(OP_READ,   32'h0000_0000,   1, res(0, 0, 0, 0, 1, 32'hFFFF_FFFF, 2)),
            chk_row(OP_READ,   32'h0000_0000,   2, res(0, 0, 0, 0, 0, 0, 2)),
            op_row(OP_APPEND,  32'hA5A5_A5A5,   0),
            op_row(OP_APPEND,  32'h0000_0000,   0),   // duplicate stored again
            op_row(OP_ADD,     32'h0000_0000,   0),   // only the front copy moves
            op_row(OP_READ,    32'h0000_0000,   3),
            op_row(OP_ADD,     32'h5A5A_5A5A,   0),
            cfg_row(SPARE_ADDR, 32'hFFFF_FFFF),
            op_row(OP_READ,    32'h0000_0000,   4),
            chk_row(OP_CLEAR,  32'h1234_5678,   0, res(0, 0, 0, 0, 0, 0, 0)),
            cfg_row(LIMIT_ADDR, 32'd2),
            op_row(OP_ADD,     32'h8000_0001,   0),
            op_row(OP_ADD,     32'h8000_0002,   0),
            chk_row(OP_ADD,    32'h8000_0003,   0, res(0, 0, 1, 32'h8000_0001, 0, 0, 2)),
            chk_row(OP_APPEND, 32'h8000_0004,   0, res(0, 0, 1, 32'h8000_0004, 0, 0, 2)),
            chk_row(OP_ADD,    32'h8000_0002,   0, res(1, 1, 0, 0, 0, 0, 2)),
            cfg_row(LIMIT_ADDR, 32'd1),           // trims the list to one key
            chk_row(OP_READ,   32'h0000_0000,   1, res(0, 0, 0, 0, 0, 0, 1)),
            cfg_row(LIMIT_ADDR, 32'hABCD_EF00),   // limit zero, upper bits ignored
            chk_row(OP_ADD,    32'h7777_7777,   0, res(0, 0, 1, 32'h7777_7777, 0, 0, 0)),
            chk_row(OP_APPEND, 32'h8888_8888,   0, res(0, 0, 1, 32'h8888_8888, 0, 0, 0)),
            chk_row(OP_READ,   32'h0000_0000,   0, res(0, 0, 0, 0, 0, 0, 0))
        };

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_ADD;
        i_key = '0;
        i_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycle_count = 0;
        steady_left = 0;
        held_count = 0;
        limit_reg = MAX_RESET;
        limit_eff = MAX_RESET;
        pool_n = 4;
        for (int i = 0; i < LIST_DEPTH; i++) held_keys[i] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg)
                write_reg(dir_rows[n].addr, dir_rows[n].wdata);
            else
                send_word(dir_rows[n].op, dir_rows[n].key, dir_rows[n].idx,
                          dir_rows[n].typed, dir_rows[n].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if ($urandom_range(0, 3) == 0) write_reg(SPARE_ADDR, $urandom);
            write_reg(LIMIT_ADDR, {24'($urandom_range(0, 32'hFF_FFFF)), 8'(phase_limit[p])});
            // long lists only fill up with a burst of appends
            if (limit_eff >= 32) begin
                while (held_count < limit_eff)
                    send_word(OP_APPEND, key_pool[$urandom_range(0, pool_n - 1)],
                              ADDR_W'(0), 1'b0, '0);
            end
            clear_at = (limit_eff >= 32) ? 99 : 96;
            repeat (phase_items[p]) begin
                r = $urandom_range(0, 99);
                if (r < 45) op = OP_ADD;
                else if (r < 70) op = OP_READ;
                else if (r < clear_at) op = OP_APPEND;
                else op = OP_CLEAR;
                if ($urandom_range(0, 4) != 0) key = key_pool[$urandom_range(0, pool_n - 1)];
                else key = $urandom;
                if (held_count > 0 && $urandom_range(0, 4) != 0)
                    idx = ADDR_W'($urandom_range(0, held_count - 1));
                else
                    idx = ADDR_W'($urandom_range(0, LIST_DEPTH - 1));
                send_word(op, key, idx, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
